FILE: design/qte_pkg.sv
// ----------------------------------------------------------------------------
// qte_pkg
// Shared types, constants and tables for the quaternion-to-Euler IMU scaler.
// ----------------------------------------------------------------------------
package qte_pkg;

  // default configuration
  localparam int DEF_CORDIC_STEPS    = 16;
  localparam int DEF_ANGLE_FRAC_BITS = 8;

  // datapath widths
  localparam int VEC_W   = 40;   // CORDIC x/y
  localparam int ANG_W   = 36;   // Q30 radian accumulator
  localparam int RAD_W   = 61;   // isqrt radicand
  localparam int ROOT_W  = 32;   // isqrt result
  localparam int ROOT_STEPS = 31; // result bits produced, one per cycle
  localparam int OUT_ANG_W  = 17;

  // beat layouts
  localparam int S_DATA_W = 256;
  localparam int M_DATA_W = 184;

  localparam logic signed [ANG_W-1:0] PI_Q30 = 36'sd3373259426;

  // gyro scaling: q = (mag*40 + 20) / 41 via reciprocal
  localparam logic [21:0] RATE_RECIP = 22'd3273604;
  localparam int          RATE_SHIFT = 27;

  // unit status between sequencer and shared units
  typedef struct packed {
    logic busy;
    logic done;
  } qte_stat_t;

  // rounded atan(2^-i) in Q30 radians
  function automatic logic signed [ANG_W-1:0] atan_q30(input logic [4:0] i);
    logic signed [ANG_W-1:0] v;
    case (i)
      5'd0:  v = 36'sd843314857;
      5'd1:  v = 36'sd497837829;
      5'd2:  v = 36'sd263043837;
      5'd3:  v = 36'sd133525159;
      5'd4:  v = 36'sd67021687;
      5'd5:  v = 36'sd33543516;
      5'd6:  v = 36'sd16775851;
      5'd7:  v = 36'sd8388437;
      5'd8:  v = 36'sd4194283;
      5'd9:  v = 36'sd2097149;
      5'd10: v = 36'sd1048576;
      5'd11: v = 36'sd524288;
      5'd12: v = 36'sd262144;
      5'd13: v = 36'sd131072;
      5'd14: v = 36'sd65536;
      5'd15: v = 36'sd32768;
      5'd16: v = 36'sd16384;
      5'd17: v = 36'sd8192;
      5'd18: v = 36'sd4096;
      5'd19: v = 36'sd2048;
      5'd20: v = 36'sd1024;
      5'd21: v = 36'sd512;
      5'd22: v = 36'sd256;
      5'd23: v = 36'sd128;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

FILE: design/qte_isqrt.sv
// ----------------------------------------------------------------------------
// qte_isqrt
// Iterative integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module qte_isqrt
  import qte_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [RAD_W-1:0]  radicand,
  output logic [ROOT_W-1:0] root,
  output qte_stat_t         stat
);

  logic [RAD_W-1:0] rem;
  logic [RAD_W:0]   acc;
  logic [4:0]       j;
  logic [RAD_W:0]   bit_w;
  logic [RAD_W:0]   trial;

  // current trial bit is 4^j
  assign bit_w = (RAD_W+1)'(1) << {j, 1'b0};
  assign trial = acc + bit_w;
  assign root  = acc[ROOT_W-1:0];

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      stat <= '0;
      j    <= '0;
    end else begin
      stat.done <= 1'b0;
      if (start) begin
        stat.busy <= 1'b1;
        j         <= 5'(ROOT_STEPS - 1);
      end else if (stat.busy) begin
        if (j == 5'd0) begin
          stat.busy <= 1'b0;
          stat.done <= 1'b1;
        end else begin
          j <= j - 5'd1;
        end
      end
    end
  end

  // restoring root step
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= radicand;
      acc <= '0;
    end else if (stat.busy) begin
      if ({1'b0, rem} >= trial) begin
        rem <= rem - trial[RAD_W-1:0];
        acc <= (acc >> 1) + bit_w;
      end else begin
        acc <= acc >> 1;
      end
    end
  end

endmodule

FILE: design/qte_cordic.sv
// ----------------------------------------------------------------------------
// qte_cordic
// Vectoring CORDIC, one micro-rotation per cycle; returns atan2(y, x) in Q30.
// ----------------------------------------------------------------------------
module qte_cordic
  import qte_pkg::*;
#(
  parameter int STEPS = DEF_CORDIC_STEPS
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic signed [VEC_W-1:0] y_in,
  input  logic signed [VEC_W-1:0] x_in,
  output logic signed [ANG_W-1:0] angle,
  output qte_stat_t               stat
);

  localparam int CNW = $clog2(STEPS);

  logic signed [VEC_W-1:0] x, y, xs, ys;
  logic [CNW-1:0]          cnt;

  assign xs = x >>> cnt;
  assign ys = y >>> cnt;

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      stat <= '0;
      cnt  <= '0;
    end else begin
      stat.done <= 1'b0;
      if (start) begin
        stat.busy <= 1'b1;
        cnt       <= '0;
      end else if (stat.busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNW'(STEPS - 1)) begin
          stat.busy <= 1'b0;
          stat.done <= 1'b1;
        end
      end
    end
  end

  // rotation datapath; left half-plane folded by negation
  always_ff @(posedge clk) begin
    if (start) begin
      if (x_in < 0) begin
        angle <= (y_in >= 0) ? PI_Q30 : -PI_Q30;
        x     <= -x_in;
        y     <= -y_in;
      end else begin
        angle <= '0;
        x     <= x_in;
        y     <= y_in;
      end
    end else if (stat.busy) begin
      if (y >= 0) begin
        x     <= x + ys;
        y     <= y - xs;
        angle <= angle + atan_q30(5'(cnt));
      end else begin
        x     <= x - ys;
        y     <= y + xs;
        angle <= angle - atan_q30(5'(cnt));
      end
    end
  end

endmodule

FILE: design/quaternion_to_euler_imu_scaler.sv
// ----------------------------------------------------------------------------
// quaternion_to_euler_imu_scaler
// Converts a Q30 attitude quaternion to pitch/roll/yaw in degrees, passes
// accel counts through and scales gyro counts; results are latched and held
// across samples that carry no quaternion.
// ----------------------------------------------------------------------------
//  channel  dir  beat payload
//  s_axis   in   tdata: quat w,x,y,z, accel x,y,z, gyro x,y,z, stamp; tuser: quat_valid
//  m_axis   out  tdata: pitch, roll, yaw, accel g x,y,z, rate x,y,z, stamp
//
//  A sample with quat_valid set runs ten products through one shared 32x32
//  multiplier, then a square root, then three CORDIC passes, before the next
//  ready. A hold sample goes from ST_IDLE straight to ST_DONE.
//  One sample is in flight at a time.
//  rst is synchronous; held results reset to zero.
//  A stalled m_axis beat holds the sequencer in its final state.
// ----------------------------------------------------------------------------
module quaternion_to_euler_imu_scaler
  import qte_pkg::*;
#(
  parameter int CORDIC_STEPS    = DEF_CORDIC_STEPS,
  parameter int ANGLE_FRAC_BITS = DEF_ANGLE_FRAC_BITS
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // w[31:0] x[63:32] y[95:64] z[127:96] accel x,y,z[175:128]
  // gyro x,y,z[223:176] stamp_in[255:224]
  input  logic [S_DATA_W-1:0] s_axis_tdata,
  input  logic                s_axis_tuser,   // quat_valid
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // pitch[16:0] roll[33:17] yaw[50:34] accel_g x,y,z[98:51]
  // rate_dps x,y,z[146:99] stamp_out[178:147] zero pad[183:179]
  output logic [M_DATA_W-1:0] m_axis_tdata
);

  // degree conversion: u = (|z|*573*2^F + 5*2^30) >> 31, q = u / 5
  localparam int DW = 35 + 10 + ANGLE_FRAC_BITS + 1;
  localparam int UW = DW - 31;
  localparam int KS = UW + 3;
  localparam longint unsigned DIV5 = ((64'd1 << KS) + 64'd4) / 64'd5;
  localparam int QW = UW + KS;

  typedef enum logic [12:0] {
    ST_IDLE  = 13'b0000000000001,
    ST_MUL   = 13'b0000000000010,
    ST_ACC   = 13'b0000000000100,
    ST_SAT   = 13'b0000000001000,
    ST_SQ    = 13'b0000000010000,
    ST_ROOT  = 13'b0000000100000,
    ST_ROOTW = 13'b0000001000000,
    ST_CORD  = 13'b0000010000000,
    ST_CORDW = 13'b0000100000000,
    ST_CONV1 = 13'b0001000000000,
    ST_CONV2 = 13'b0010000000000,
    ST_RATE  = 13'b0100000000000,
    ST_DONE  = 13'b1000000000000
  } state_t;

  state_t state;

  logic [S_DATA_W-1:0]       in_r;
  logic                      qv_r;
  logic [3:0]                idx;
  logic [1:0]                k;
  logic signed [33:0]        p [10];
  logic signed [31:0]        mul_a, mul_b;
  logic signed [63:0]        prod;
  logic signed [31:0]        s_r;
  logic [ROOT_W-1:0]         c_r;
  logic signed [ANG_W-1:0]   z_r;
  logic [UW-1:0]             u_r;
  logic                      neg_r;

  logic signed [OUT_ANG_W-1:0] held_angle [3];
  logic [15:0]                 held_accel [3];
  logic [15:0]                 held_rate [3];
  logic [31:0]                 held_stamp;

  // quaternion fields
  logic signed [31:0] qw, qx, qy, qz;
  assign qw = $signed(in_r[31:0]);
  assign qx = $signed(in_r[63:32]);
  assign qy = $signed(in_r[95:64]);
  assign qz = $signed(in_r[127:96]);

  // multiplier operand select
  always_comb begin
    mul_a = s_r;
    mul_b = s_r;
    if (state == ST_MUL) begin
      case (idx)
        4'd0:    begin mul_a = qx; mul_b = qz; end
        4'd1:    begin mul_a = qw; mul_b = qy; end
        4'd2:    begin mul_a = qy; mul_b = qz; end
        4'd3:    begin mul_a = qw; mul_b = qx; end
        4'd4:    begin mul_a = qx; mul_b = qx; end
        4'd5:    begin mul_a = qy; mul_b = qy; end
        4'd6:    begin mul_a = qx; mul_b = qy; end
        4'd7:    begin mul_a = qw; mul_b = qz; end
        4'd8:    begin mul_a = qw; mul_b = qw; end
        4'd9:    begin mul_a = qz; mul_b = qz; end
        default: begin mul_a = qw; mul_b = qw; end
      endcase
    end
  end

  // shared multiplier, registered
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // Euler vector components in Q30
  logic signed [36:0] s_full, ry, rx, yy, yx;
  logic signed [31:0] s_sat;
  assign s_full = (37'(p[0]) - 37'(p[1])) <<< 1;
  assign ry     = (37'(p[2]) + 37'(p[3])) <<< 1;
  assign rx     = 37'sd1073741824 - ((37'(p[4]) + 37'(p[5])) <<< 1);
  assign yy     = (37'(p[6]) + 37'(p[7])) <<< 1;
  assign yx     = 37'(p[8]) + 37'(p[4]) - 37'(p[5]) - 37'(p[9]);

  // asin argument clamp to +/-1
  always_comb begin
    if (s_full > 37'sd1073741824)       s_sat = 32'sd1073741824;
    else if (s_full < -37'sd1073741824) s_sat = -32'sd1073741824;
    else                                s_sat = 32'(s_full);
  end

  // square root unit
  logic [ROOT_W-1:0] root_val;
  qte_stat_t         root_stat;
  logic              root_start;
  assign root_start = (state == ST_ROOT);

  qte_isqrt u_root (
    .clk      (clk),
    .rst      (rst),
    .start    (root_start),
    .radicand ((RAD_W)'(64'd1 << 60) - prod[RAD_W-1:0]),
    .root     (root_val),
    .stat     (root_stat)
  );

  // CORDIC unit
  logic signed [VEC_W-1:0] cy, cx;
  logic signed [ANG_W-1:0] cord_z;
  qte_stat_t               cord_stat;
  logic                    cord_start;
  assign cord_start = (state == ST_CORD);

  always_comb begin
    case (k)
      2'd0:    begin cy = 40'(s_r); cx = $signed(40'(c_r)); end
      2'd1:    begin cy = 40'(ry);  cx = 40'(rx); end
      default: begin cy = 40'(yy);  cx = 40'(yx); end
    endcase
  end

  qte_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (cord_start),
    .y_in  (cy),
    .x_in  (cx),
    .angle (cord_z),
    .stat  (cord_stat)
  );

  // degree conversion terms
  logic [34:0]     z_mag;
  logic [DW-1:0]   z_scaled;
  logic [QW-1:0]   q_prod;
  logic [UW-1:0]   q_deg;
  logic signed [OUT_ANG_W-1:0] ang_sat;
  assign z_mag    = 35'(z_r[ANG_W-1] ? -z_r : z_r);
  assign z_scaled = ((DW'(z_mag) * DW'(573)) << ANGLE_FRAC_BITS) + DW'(64'd5368709120);
  assign q_prod   = QW'(u_r) * QW'(DIV5);
  assign q_deg    = q_prod[QW-1:KS];

  always_comb begin
    if (neg_r) begin
      if (q_deg > UW'(65536)) ang_sat = -17'sd65536;
      else                    ang_sat = 17'(-$signed({1'b0, q_deg}));
    end else begin
      if (q_deg > UW'(65535)) ang_sat = 17'sd65535;
      else                    ang_sat = 17'(q_deg);
    end
  end

  // gyro lanes: raw*40/41 rounded half away from zero
  logic [15:0] rate_new [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      logic signed [16:0] rs;
      logic [16:0]        rmag;
      logic [21:0]        rx40;
      logic [43:0]        rq;
      rs   = 17'($signed(in_r[176 + 16*i +: 16]));
      rmag = 17'(rs < 0 ? -rs : rs);
      rx40 = 22'(rmag) * 22'd40 + 22'd20;
      rq   = 44'(rx40) * 44'(RATE_RECIP);
      rate_new[i] = rs < 0 ? 16'(-rq[RATE_SHIFT +: 16]) : rq[RATE_SHIFT +: 16];
    end
  end

  assign s_axis_tready = (state == ST_IDLE);

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      idx   <= '0;
      k     <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            idx   <= '0;
            k     <= '0;
            state <= s_axis_tuser ? ST_MUL : ST_DONE;
          end
        end
        ST_MUL:   state <= ST_ACC;
        ST_ACC: begin
          if (idx == 4'd9) begin
            state <= ST_SAT;
          end else begin
            idx   <= idx + 4'd1;
            state <= ST_MUL;
          end
        end
        ST_SAT:   state <= ST_SQ;
        ST_SQ:    state <= ST_ROOT;
        ST_ROOT:  state <= ST_ROOTW;
        ST_ROOTW: if (root_stat.done) state <= ST_CORD;
        ST_CORD:  state <= ST_CORDW;
        ST_CORDW: if (cord_stat.done) state <= ST_CONV1;
        ST_CONV1: state <= ST_CONV2;
        ST_CONV2: begin
          if (k == 2'd2) begin
            state <= ST_RATE;
          end else begin
            k     <= k + 2'd1;
            state <= ST_CORD;
          end
        end
        ST_RATE:  state <= ST_DONE;
        ST_DONE:  if (!m_axis_tvalid || m_axis_tready) state <= ST_IDLE;
        default:  state <= ST_IDLE;
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_r <= s_axis_tdata;
      qv_r <= s_axis_tuser;
    end
    if (state == ST_ACC) p[idx] <= prod[63:30];
    if (state == ST_SAT) s_r <= s_sat;
    if (state == ST_ROOTW && root_stat.done) c_r <= root_val;
    if (state == ST_CORDW && cord_stat.done) z_r <= cord_z;
    if (state == ST_CONV1) begin
      u_r   <= z_scaled[DW-1:31];
      neg_r <= z_r[ANG_W-1];
    end
  end

  // held results
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        held_angle[i] <= '0;
        held_accel[i] <= '0;
        held_rate[i]  <= '0;
      end
      held_stamp <= '0;
    end else begin
      if (state == ST_CONV2) held_angle[k] <= ang_sat;
      if (state == ST_RATE) begin
        for (int i = 0; i < 3; i++) begin
          held_accel[i] <= in_r[128 + 16*i +: 16];
          held_rate[i]  <= rate_new[i];
        end
        held_stamp <= in_r[255:224];
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (state == ST_DONE && (!m_axis_tvalid || m_axis_tready)) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && (!m_axis_tvalid || m_axis_tready)) begin
      m_axis_tdata <= {5'd0, held_stamp,
                       held_rate[2], held_rate[1], held_rate[0],
                       held_accel[2], held_accel[1], held_accel[0],
                       held_angle[2], held_angle[1], held_angle[0]};
    end
  end

`ifndef SYNTH
  // shared units idle whenever a new beat can be taken
  assert property (@(posedge clk) disable iff (rst)
    s_axis_tready |-> (!root_stat.busy && !cord_stat.busy))
    else $error("unit busy while sequencer idle");

  // cosine of pitch never exceeds one
  assert property (@(posedge clk) disable iff (rst)
    root_stat.done |-> (root_val <= 32'd1073741824))
    else $error("square root out of range");

  // one sample in flight
  assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("second beat accepted while busy");

  // hold samples leave the latched pitch angle untouched
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && !qv_r) |-> $stable(held_angle[0]))
    else $error("angle changed on hold sample");
`endif

endmodule
